FILE: rtl/semtbl_pkg.sv
// ----------------------------------------------------------------------------
// semtbl_pkg
// Request and result types, operation and status codes, and the command and
// status bundles between the semaphore table controller and datapath.
// ----------------------------------------------------------------------------
package semtbl_pkg;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_OPEN  = 3'd1;
    localparam logic [2:0] OP_CLOSE = 3'd2;
    localparam logic [2:0] OP_WAIT  = 3'd3;
    localparam logic [2:0] OP_POST  = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] sem_id;
        logic [7:0] init_value;
        logic [7:0] requester_pid;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       wake_valid;
        logic [7:0] wake_pid;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic wake;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_wake;
    } dp_stat_t;

endpackage

FILE: rtl/semtbl_ctrl.sv
// ----------------------------------------------------------------------------
// semtbl_ctrl
// Sequencer for the semaphore table: accept a request, run the entry
// read-modify-write, and fetch the released waiter when a post wakes one.
// ----------------------------------------------------------------------------
module semtbl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output semtbl_pkg::ctrl_cmd_t  cmd,
    input  semtbl_pkg::dp_stat_t   stat
);
    import semtbl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAKE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.need_wake ? S_WAKE : S_IDLE;
            end
            S_WAKE:
            begin
                cmd.wake   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.wake}))
        else $error("controller issued more than one command");

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted request not executed in the next cycle");

    a_wake_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wake |-> $past(cmd.exec && stat.need_wake))
        else $error("waiter fetch without a post that needs it");
`endif

endmodule

FILE: rtl/semtbl_dp.sv
// ----------------------------------------------------------------------------
// semtbl_dp
// Datapath: semaphore entry memory with per-entry valid bits, the waiter
// memory holding all FIFO queues, request decode and the result register.
// ----------------------------------------------------------------------------
module semtbl_dp #(
    parameter int SEM_COUNT       = 32,
    parameter int WAITERS_PER_SEM = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  semtbl_pkg::req_t       req,
    input  semtbl_pkg::ctrl_cmd_t  cmd,
    output semtbl_pkg::dp_stat_t   stat,
    output logic                   done,
    output semtbl_pkg::res_t       result
);
    import semtbl_pkg::*;

    localparam int SI_W  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int HW    = (WAITERS_PER_SEM > 1) ? $clog2(WAITERS_PER_SEM) : 1;
    localparam int FW    = $clog2(WAITERS_PER_SEM + 1);
    localparam int PW    = FW + 1;
    localparam int DEPTH = SEM_COUNT * WAITERS_PER_SEM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic          open;
        logic [7:0]    count;
        logic [HW-1:0] head;
        logic [FW-1:0] fill;
    } entry_t;

    entry_t          sem_mem [SEM_COUNT];
    logic [7:0]      wq_mem  [DEPTH];

    logic [SEM_COUNT-1:0] vld_reg;
    logic                 vld_rd_reg;
    entry_t               ent_rd_reg;
    req_t                 req_reg;
    logic                 in_range_reg;
    logic [AW-1:0]        base_reg;
    logic [7:0]           wrd_reg;
    res_t                 res_reg;
    logic                 done_reg;

    logic [SI_W-1:0]      idx_in;
    logic [SI_W-1:0]      idx_cur;
    logic                 in_range_in;
    entry_t               cur;
    entry_t               ent_next;
    logic [1:0]           status_c;
    logic                 ent_we;
    logic                 wq_we;
    logic                 wq_re;
    logic                 need_wake;
    logic [PW-1:0]        pos_sum;
    logic [PW-1:0]        pos_mod;
    logic [HW:0]          head_inc;
    logic [HW-1:0]        head_adv;
    logic [AW-1:0]        wq_waddr;
    logic [AW-1:0]        wq_raddr;

    assign idx_in      = req.sem_id[SI_W-1:0];
    assign idx_cur     = req_reg.sem_id[SI_W-1:0];
    assign in_range_in = ({1'b0, req.sem_id} < 9'(SEM_COUNT));

    // capture the request, fetch its semaphore entry and write back the new entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req;
            in_range_reg <= in_range_in;
            base_reg     <= AW'(idx_in) * AW'(WAITERS_PER_SEM);
            ent_rd_reg   <= sem_mem[idx_in];
            vld_rd_reg   <= vld_reg[idx_in];
        end
        if (ent_we)
        begin
            sem_mem[idx_cur] <= ent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ent_we)
        begin
            vld_reg[idx_cur] <= 1'b1;
        end
    end

    // an entry never written reads as a free, empty semaphore
    assign cur = vld_rd_reg ? ent_rd_reg : '0;

    assign pos_sum  = PW'(cur.head) + PW'(cur.fill);
    assign pos_mod  = (pos_sum >= PW'(WAITERS_PER_SEM)) ?
                      (pos_sum - PW'(WAITERS_PER_SEM)) : pos_sum;
    assign head_inc = {1'b0, cur.head} + (HW + 1)'(1);
    assign head_adv = (head_inc == (HW + 1)'(WAITERS_PER_SEM)) ? '0 : head_inc[HW-1:0];
    assign wq_waddr = base_reg + AW'(pos_mod[HW-1:0]);
    assign wq_raddr = base_reg + AW'(cur.head);

    always_comb
    begin
        status_c  = ST_ERROR;
        ent_next  = cur;
        ent_we    = 1'b0;
        wq_we     = 1'b0;
        wq_re     = 1'b0;
        need_wake = 1'b0;
        if (cmd.exec && in_range_reg)
        begin
            case (req_reg.func)
                OP_INIT:
                begin
                    if (!cur.open)
                    begin
                        ent_next.open  = 1'b1;
                        ent_next.count = req_reg.init_value;
                        ent_next.head  = '0;
                        ent_next.fill  = '0;
                        ent_we         = 1'b1;
                        status_c       = ST_DONE;
                    end
                end
                OP_OPEN:
                begin
                    if (!cur.open)
                    begin
                        status_c = ST_DONE;
                    end
                end
                OP_CLOSE:
                begin
                    if (cur.open)
                    begin
                        ent_next = '0;
                        ent_we   = 1'b1;
                        status_c = ST_DONE;
                    end
                end
                OP_WAIT:
                begin
                    if (cur.open)
                    begin
                        if (cur.count != 8'd0)
                        begin
                            ent_next.count = cur.count - 8'd1;
                            ent_we         = 1'b1;
                            status_c       = ST_DONE;
                        end
                        else if (cur.fill < FW'(WAITERS_PER_SEM))
                        begin
                            ent_next.fill = cur.fill + FW'(1);
                            ent_we        = 1'b1;
                            wq_we         = 1'b1;
                            status_c      = ST_QUEUED;
                        end
                    end
                end
                OP_POST:
                begin
                    if (cur.open)
                    begin
                        status_c = ST_DONE;
                        if (cur.fill != '0)
                        begin
                            // release the oldest waiter, count stays put
                            ent_next.head = head_adv;
                            ent_next.fill = cur.fill - FW'(1);
                            ent_we        = 1'b1;
                            wq_re         = 1'b1;
                            need_wake     = 1'b1;
                        end
                        else if (cur.count != COUNT_MAX)
                        begin
                            ent_next.count = cur.count + 8'd1;
                            ent_we         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_c = ST_ERROR;
                end
            endcase
        end
    end

    assign stat.need_wake = need_wake;

    always_ff @(posedge clk)
    begin
        if (wq_we)
        begin
            wq_mem[wq_waddr] <= req_reg.requester_pid;
        end
        if (wq_re)
        begin
            wrd_reg <= wq_mem[wq_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && !need_wake)
        begin
            res_reg.status     <= status_c;
            res_reg.wake_valid <= 1'b0;
            res_reg.wake_pid   <= 8'd0;
        end
        else if (cmd.wake)
        begin
            res_reg.status     <= ST_DONE;
            res_reg.wake_valid <= 1'b1;
            res_reg.wake_pid   <= wrd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.exec && !need_wake) || cmd.wake;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_wake_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.wake_valid) |-> (result.status == ST_DONE))
        else $error("wake reported with a status other than done");

    a_no_wake_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.wake_valid) |-> (result.wake_pid == 8'd0))
        else $error("wake pid not cleared on a result without a wake");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(wq_we && wq_re))
        else $error("waiter memory written and read for one request");
`endif

endmodule

FILE: rtl/semaphore_table_with_wait_queues_unit.sv
// Sequence: an accepted request is captured with its entry fetched, then
//   executed as a read-modify-write of the entry, and done is registered; a
//   post that releases a waiter also reads the waiter memory and passes the
//   wake state first. A new request is taken only while busy is low.
// Reset: counts, open flags and queues clear at once through per-entry valid
//   bits; the waiter memory is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
// semaphore_table_with_wait_queues_unit
// Table of counting semaphores, each with a FIFO queue of waiting process ids.
// ----------------------------------------------------------------------------
module semaphore_table_with_wait_queues_unit #(
    parameter int SEM_COUNT       = 32,
    parameter int WAITERS_PER_SEM = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  semtbl_pkg::req_t   req,
    output logic               done,
    output semtbl_pkg::res_t   result
);
    import semtbl_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    semtbl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    semtbl_dp #(
        .SEM_COUNT       (SEM_COUNT),
        .WAITERS_PER_SEM (WAITERS_PER_SEM)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule
